// ----- hdl/etlc_pkg.sv -----
package etlc_pkg;

   // Level codes reported in the response word.
   localparam logic [2:0] LVL_L1    = 3'd0;
   localparam logic [2:0] LVL_L2    = 3'd1;
   localparam logic [2:0] LVL_L3    = 3'd2;
   localparam logic [2:0] LVL_MAIN  = 3'd3;
   localparam logic [2:0] LVL_STORE = 3'd4;

   // Codes of the level currently being searched.
   localparam logic [1:0] SCAN_L1   = 2'd0;
   localparam logic [1:0] SCAN_L2   = 2'd1;
   localparam logic [1:0] SCAN_L3   = 2'd2;
   localparam logic [1:0] SCAN_MAIN = 2'd3;

   // Per-level access costs.
   localparam logic [5:0] COST_L1    = 6'd10;
   localparam logic [5:0] COST_L2    = 6'd11;
   localparam logic [5:0] COST_L3    = 6'd12;
   localparam logic [5:0] COST_MAIN  = 6'd13;
   localparam logic [5:0] COST_STORE = 6'd14;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       scan_start;
      logic [1:0] level;
      logic       commit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic hit;
      logic out_free;
   } status_type;

   // Accumulated cost of an access that ends at the given level.
   function automatic logic [5:0] cost_of(input logic [2:0] lvl);
      logic [5:0] c;
      unique case (lvl)
         LVL_L1:   c = COST_L1;
         LVL_L2:   c = COST_L1 + COST_L2;
         LVL_L3:   c = COST_L1 + COST_L2 + COST_L3;
         LVL_MAIN: c = COST_L1 + COST_L2 + COST_L3 + COST_MAIN;
         default:  c = COST_L1 + COST_L2 + COST_L3 + COST_MAIN + COST_STORE;
      endcase
      return c;
   endfunction

endpackage

// ----- hdl/exclusive_three_level_cache_lru.sv -----
// Exclusive three-level cache with LRU replacement, plus main memory.
// Request channel: req_valid/req_stall carry one block address per word.
// Response channel: rsp_valid/rsp_stall carry one word per request with the
// level where the block was found, its cost, the L1 slot now holding it and
// any block written back from main memory.
// Each request searches L1, then L2, L3 and main memory in turn, stopping at
// the first hit. Each level is scanned in full: one entry is read per cycle
// from its store, which has one read port and one write port. One request is
// worked on at a time; the next request is accepted as soon as the previous
// response is loaded into the output register, even while that response is
// still stalled.
// Reset clears all valid bits and the access clock; no clearing pass runs.
// While rsp_stall is high, the response holds and a finished request waits
// before its updates are committed.
module exclusive_three_level_cache_lru #(
   parameter int L1_SLOTS   = 16,
   parameter int L2_SLOTS   = 32,
   parameter int L3_SLOTS   = 64,
   parameter int MAIN_SLOTS = 256,
   parameter int ADDR_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_block_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_hit_level,
   output logic [5:0]  rsp_access_cost,
   output logic [3:0]  rsp_l1_slot,
   output logic        rsp_evict_valid,
   output logic [15:0] rsp_evict_address
);
   import etlc_pkg::*;

   cmd_type    cmd;
   status_type status;

   etlc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   etlc_datapath #(
      .L1_SLOTS   (L1_SLOTS),
      .L2_SLOTS   (L2_SLOTS),
      .L3_SLOTS   (L3_SLOTS),
      .MAIN_SLOTS (MAIN_SLOTS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_block_address (req_block_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit_level     (rsp_hit_level),
      .rsp_access_cost   (rsp_access_cost),
      .rsp_l1_slot       (rsp_l1_slot),
      .rsp_evict_valid   (rsp_evict_valid),
      .rsp_evict_address (rsp_evict_address)
   );

endmodule

// ----- hdl/etlc_level.sv -----
module etlc_level #(
   parameter int SLOTS     = 16,
   parameter int ADDR_BITS = 16,
   parameter int W         = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [W-1:0]         rd_idx,
   output logic                 rd_valid,
   output logic [ADDR_BITS-1:0] rd_addr,
   output logic [31:0]          rd_stamp,
   input  logic                 wr_en,
   input  logic [W-1:0]         wr_idx,
   input  logic                 wr_valid,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [31:0]          wr_stamp
);

   logic [ADDR_BITS-1:0] addr_mem [SLOTS];
   logic [31:0]          stamp_mem [SLOTS];
   logic [SLOTS-1:0]     valid_ff;
   logic                 rvalid_ff;
   logic [ADDR_BITS-1:0] raddr_ff;
   logic [31:0]          rstamp_ff;

   // Valid bits are cleared by reset; the entries themselves are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= wr_valid;
      end
   end

   // Entry storage with one write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         addr_mem[wr_idx]  <= wr_addr;
         stamp_mem[wr_idx] <= wr_stamp;
      end
   end

   // Registered read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rvalid_ff <= valid_ff[rd_idx];
         raddr_ff  <= addr_mem[rd_idx];
         rstamp_ff <= stamp_mem[rd_idx];
      end
   end

   // An entry that is not valid reads as cleared.
   assign rd_valid = rvalid_ff;
   assign rd_addr  = rvalid_ff ? raddr_ff : '0;
   assign rd_stamp = rvalid_ff ? rstamp_ff : '0;

endmodule

// ----- hdl/etlc_ctrl.sv -----
module etlc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output etlc_pkg::cmd_type    cmd,
   input  etlc_pkg::status_type status
);
   import etlc_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] lvl_ff, lvl_in;

   // State and level registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lvl_ff   <= SCAN_L1;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      lvl_in         = lvl_ff;
      cmd            = '0;
      cmd.level      = lvl_ff;
      req_stall      = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               lvl_in     = SCAN_L1;
               state_in   = ST_START;
            end
         end
         ST_START: begin
            cmd.scan_start = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               if (status.hit || lvl_ff == SCAN_MAIN) begin
                  state_in = ST_COMMIT;
               end else begin
                  lvl_in   = lvl_ff + 2'd1;
                  state_in = ST_START;
               end
            end
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- hdl/etlc_datapath.sv -----
module etlc_datapath #(
   parameter int L1_SLOTS   = 16,
   parameter int L2_SLOTS   = 32,
   parameter int L3_SLOTS   = 64,
   parameter int MAIN_SLOTS = 256,
   parameter int ADDR_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  etlc_pkg::cmd_type    cmd,
   output etlc_pkg::status_type status,
   input  logic [15:0]          req_block_address,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_hit_level,
   output logic [5:0]           rsp_access_cost,
   output logic [3:0]           rsp_l1_slot,
   output logic                 rsp_evict_valid,
   output logic [15:0]          rsp_evict_address
);
   import etlc_pkg::*;

   localparam int W1  = (L1_SLOTS > 1) ? $clog2(L1_SLOTS) : 1;
   localparam int W2  = (L2_SLOTS > 1) ? $clog2(L2_SLOTS) : 1;
   localparam int W3  = (L3_SLOTS > 1) ? $clog2(L3_SLOTS) : 1;
   localparam int WM  = (MAIN_SLOTS > 1) ? $clog2(MAIN_SLOTS) : 1;
   localparam int WA  = (W1 > W2) ? W1 : W2;
   localparam int WB  = (W3 > WM) ? W3 : WM;
   localparam int WX  = (WA > WB) ? WA : WB;
   localparam logic [WX-1:0] LAST1 = WX'(L1_SLOTS - 1);
   localparam logic [WX-1:0] LAST2 = WX'(L2_SLOTS - 1);
   localparam logic [WX-1:0] LAST3 = WX'(L3_SLOTS - 1);
   localparam logic [WX-1:0] LASTM = WX'(MAIN_SLOTS - 1);

   // Request and clock.
   logic [ADDR_BITS-1:0] addr_ff;
   logic [31:0]          clk_ff;

   // Scan sequencing.
   logic [1:0]    lvl_ff;
   logic          issue_ff, pipe_vld_ff, done_ff;
   logic [WX-1:0] cnt_ff, pipe_idx_ff, last;

   // Scan results of the level being searched.
   logic                 found_ff, empty_ff, old_valid_ff;
   logic [WX-1:0]        match_ff, empty_idx_ff, old_idx_ff;
   logic [31:0]          best_ff, old_stamp_ff;
   logic [ADDR_BITS-1:0] old_addr_ff;

   // Replacement slot and displaced entry kept per level.
   logic [W1-1:0]        pick1_ff;
   logic [W2-1:0]        pick2_ff;
   logic [W3-1:0]        pick3_ff;
   logic [WM-1:0]        pickm_ff;
   logic                 v1_valid_ff, v2_valid_ff, v3_valid_ff;
   logic [ADDR_BITS-1:0] v1_addr_ff, v2_addr_ff, v3_addr_ff, ev_addr_ff;
   logic [31:0]          v1_stamp_ff, v2_stamp_ff, v3_stamp_ff;
   logic                 ev_full_ff;

   // Level read and write ports.
   logic                 rd_valid [4];
   logic [ADDR_BITS-1:0] rd_addr [4];
   logic [31:0]          rd_stamp [4];
   logic                 e_valid;
   logic [ADDR_BITS-1:0] e_addr;
   logic [31:0]          e_stamp;
   logic [2:0]           hit_lvl;
   logic [WX-1:0]        pick_idx;
   logic [W1-1:0]        l1_idx;
   logic [W2-1:0]        l2_idx;
   logic [W3-1:0]        l3_idx;
   logic [WM-1:0]        lm_idx;
   logic                 rsp_valid_ff;

   // Last index of the level being searched.
   always_comb begin
      unique case (lvl_ff)
         SCAN_L1: last = LAST1;
         SCAN_L2: last = LAST2;
         SCAN_L3: last = LAST3;
         default: last = LASTM;
      endcase
   end

   // Read data of the level being searched.
   always_comb begin
      unique case (lvl_ff)
         SCAN_L1: begin
            e_valid = rd_valid[0]; e_addr = rd_addr[0]; e_stamp = rd_stamp[0];
         end
         SCAN_L2: begin
            e_valid = rd_valid[1]; e_addr = rd_addr[1]; e_stamp = rd_stamp[1];
         end
         SCAN_L3: begin
            e_valid = rd_valid[2]; e_addr = rd_addr[2]; e_stamp = rd_stamp[2];
         end
         default: begin
            e_valid = rd_valid[3]; e_addr = rd_addr[3]; e_stamp = rd_stamp[3];
         end
      endcase
   end

   // Accept a request word and advance the access clock.
   always_ff @(posedge clock) begin
      if (reset) begin
         clk_ff <= '0;
      end else if (cmd.accept) begin
         clk_ff <= clk_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         addr_ff <= ADDR_BITS'(req_block_address);
      end
   end

   // Scan counter and read pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff    <= 1'b0;
         pipe_vld_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         pipe_vld_ff <= issue_ff;
         done_ff     <= pipe_vld_ff && pipe_idx_ff == last;
         if (cmd.scan_start) begin
            issue_ff <= 1'b1;
         end else if (issue_ff && cnt_ff == last) begin
            issue_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pipe_idx_ff <= cnt_ff;
      if (cmd.scan_start) begin
         cnt_ff <= '0;
         lvl_ff <= cmd.level;
      end else if (issue_ff) begin
         cnt_ff <= cnt_ff + WX'(1);
      end
   end

   // Tag match, first empty slot and oldest stamp over the level.
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         found_ff <= 1'b0;
         empty_ff <= 1'b0;
      end else if (pipe_vld_ff) begin
         if (!found_ff && e_valid && e_addr == addr_ff) begin
            found_ff <= 1'b1;
            match_ff <= pipe_idx_ff;
         end
         if (!empty_ff && !e_valid) begin
            empty_ff     <= 1'b1;
            empty_idx_ff <= pipe_idx_ff;
         end
         if (pipe_idx_ff == '0 || e_stamp < best_ff) begin
            best_ff      <= (e_stamp < clk_ff) ? e_stamp : clk_ff;
            old_idx_ff   <= pipe_idx_ff;
            old_valid_ff <= e_valid;
            old_addr_ff  <= e_addr;
            old_stamp_ff <= e_stamp;
         end
      end
   end

   assign pick_idx = empty_ff ? empty_idx_ff : old_idx_ff;

   // Keep the replacement choice of each level once its scan ends.
   always_ff @(posedge clock) begin
      if (done_ff) begin
         case (lvl_ff)
            SCAN_L1: begin
               pick1_ff    <= W1'(pick_idx);
               v1_valid_ff <= !empty_ff && old_valid_ff;
               v1_addr_ff  <= empty_ff ? '0 : old_addr_ff;
               v1_stamp_ff <= empty_ff ? '0 : old_stamp_ff;
            end
            SCAN_L2: begin
               pick2_ff    <= W2'(pick_idx);
               v2_valid_ff <= !empty_ff && old_valid_ff;
               v2_addr_ff  <= empty_ff ? '0 : old_addr_ff;
               v2_stamp_ff <= empty_ff ? '0 : old_stamp_ff;
            end
            SCAN_L3: begin
               pick3_ff    <= W3'(pick_idx);
               v3_valid_ff <= !empty_ff && old_valid_ff;
               v3_addr_ff  <= empty_ff ? '0 : old_addr_ff;
               v3_stamp_ff <= empty_ff ? '0 : old_stamp_ff;
            end
            default: begin
               pickm_ff   <= WM'(pick_idx);
               ev_full_ff <= !empty_ff;
               ev_addr_ff <= old_addr_ff;
            end
         endcase
      end
   end

   // Where the block was found, and the slots written on commit.
   assign hit_lvl = found_ff ? {1'b0, lvl_ff} : LVL_STORE;
   assign l1_idx  = (hit_lvl == LVL_L1)   ? W1'(match_ff) : pick1_ff;
   assign l2_idx  = (hit_lvl == LVL_L2)   ? W2'(match_ff) : pick2_ff;
   assign l3_idx  = (hit_lvl == LVL_L3)   ? W3'(match_ff) : pick3_ff;
   assign lm_idx  = (hit_lvl == LVL_MAIN) ? WM'(match_ff) : pickm_ff;

   etlc_level #(.SLOTS(L1_SLOTS), .ADDR_BITS(ADDR_BITS), .W(W1)) u_l1 (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (issue_ff && lvl_ff == SCAN_L1),
      .rd_idx   (W1'(cnt_ff)),
      .rd_valid (rd_valid[0]),
      .rd_addr  (rd_addr[0]),
      .rd_stamp (rd_stamp[0]),
      .wr_en    (cmd.commit),
      .wr_idx   (l1_idx),
      .wr_valid (1'b1),
      .wr_addr  (addr_ff),
      .wr_stamp (clk_ff)
   );

   etlc_level #(.SLOTS(L2_SLOTS), .ADDR_BITS(ADDR_BITS), .W(W2)) u_l2 (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (issue_ff && lvl_ff == SCAN_L2),
      .rd_idx   (W2'(cnt_ff)),
      .rd_valid (rd_valid[1]),
      .rd_addr  (rd_addr[1]),
      .rd_stamp (rd_stamp[1]),
      .wr_en    (cmd.commit && hit_lvl != LVL_L1),
      .wr_idx   (l2_idx),
      .wr_valid (v1_valid_ff),
      .wr_addr  (v1_addr_ff),
      .wr_stamp (v1_stamp_ff)
   );

   etlc_level #(.SLOTS(L3_SLOTS), .ADDR_BITS(ADDR_BITS), .W(W3)) u_l3 (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (issue_ff && lvl_ff == SCAN_L3),
      .rd_idx   (W3'(cnt_ff)),
      .rd_valid (rd_valid[2]),
      .rd_addr  (rd_addr[2]),
      .rd_stamp (rd_stamp[2]),
      .wr_en    (cmd.commit && hit_lvl != LVL_L1 && hit_lvl != LVL_L2),
      .wr_idx   (l3_idx),
      .wr_valid (v2_valid_ff),
      .wr_addr  (v2_addr_ff),
      .wr_stamp (v2_stamp_ff)
   );

   etlc_level #(.SLOTS(MAIN_SLOTS), .ADDR_BITS(ADDR_BITS), .W(WM)) u_main (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (issue_ff && lvl_ff == SCAN_MAIN),
      .rd_idx   (WM'(cnt_ff)),
      .rd_valid (rd_valid[3]),
      .rd_addr  (rd_addr[3]),
      .rd_stamp (rd_stamp[3]),
      .wr_en    (cmd.commit && (hit_lvl == LVL_MAIN || hit_lvl == LVL_STORE)),
      .wr_idx   (lm_idx),
      .wr_valid (v3_valid_ff),
      .wr_addr  (v3_addr_ff),
      .wr_stamp (v3_stamp_ff)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_level     <= hit_lvl;
         rsp_access_cost   <= cost_of(hit_lvl);
         rsp_l1_slot       <= 4'(l1_idx);
         rsp_evict_valid   <= (hit_lvl == LVL_STORE) && ev_full_ff;
         rsp_evict_address <= ((hit_lvl == LVL_STORE) && ev_full_ff) ?
                              16'(ev_addr_ff) : 16'd0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign status.scan_done = done_ff;
   assign status.hit       = found_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
   import etlc_pkg::*;

   localparam int N_L1   = 16;
   localparam int N_L2   = 32;
   localparam int N_L3   = 64;
   localparam int N_MAIN = 256;

   // Level indexes of the hierarchy model.
   localparam int IX_L1   = 0;
   localparam int IX_L2   = 1;
   localparam int IX_L3   = 2;
   localparam int IX_MAIN = 3;

   typedef struct {
      bit        valid;
      bit [15:0] addr;
      bit [31:0] stamp;
   } line_type;

   typedef struct {
      logic [2:0]  hit_level;
      logic [5:0]  access_cost;
      logic [3:0]  l1_slot;
      logic        evict_valid;
      logic [15:0] evict_address;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_block_address = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_hit_level;
   logic [5:0]  rsp_access_cost;
   logic [3:0]  rsp_l1_slot;
   logic        rsp_evict_valid;
   logic [15:0] rsp_evict_address;

   line_type    hierarchy [4][N_MAIN];
   int          level_size [4] = '{N_L1, N_L2, N_L3, N_MAIN};
   bit [31:0]   use_clock;
   outcome_type pending_outcomes [$];
   int          error_count = 0;
   bit          quiet = 1'b0;

   exclusive_three_level_cache_lru DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_block_address(req_block_address),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit_level(rsp_hit_level),
      .rsp_access_cost(rsp_access_cost), .rsp_l1_slot(rsp_l1_slot),
      .rsp_evict_valid(rsp_evict_valid), .rsp_evict_address(rsp_evict_address)
   );

   always #1 clock = ~clock;

   // Idle length: mostly short, a few long, none during quiet stretches.
   function automatic int idle_length();
      int r;
      r = $urandom_range(99);
      if (quiet || r < 40) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic int find_line(int lv, bit [15:0] a);
      for (int k = 0; k < level_size[lv]; k++)
         if (hierarchy[lv][k].valid && hierarchy[lv][k].addr == a) return k;
      return -1;
   endfunction

   // Least recently stamped line; ties keep the earliest, stamps must be below the clock.
   function automatic int oldest_line(int lv);
      bit [31:0] best;
      int pos;
      best = use_clock;
      pos = 0;
      for (int k = 0; k < level_size[lv]; k++)
         if (hierarchy[lv][k].stamp < best) begin
            best = hierarchy[lv][k].stamp;
            pos = k;
         end
      return pos;
   endfunction

   function automatic int victim_line(int lv);
      for (int k = 0; k < level_size[lv]; k++)
         if (!hierarchy[lv][k].valid) return k;
      return oldest_line(lv);
   endfunction

   // Move the block at (lv, idx) one level up, swapping the victim down.
   function automatic int lift_block(int lv, int idx);
      int dst;
      line_type t;
      dst = victim_line(lv - 1);
      t = hierarchy[lv - 1][dst];
      hierarchy[lv - 1][dst] = hierarchy[lv][idx];
      hierarchy[lv][idx] = t;
      return dst;
   endfunction

   // Work out the outcome of one access and update the hierarchy model.
   function automatic outcome_type access_block(bit [15:0] a);
      outcome_type o;
      int lv, k;
      o.hit_level = LVL_L1;
      o.access_cost = COST_L1;
      o.evict_valid = 1'b0;
      o.evict_address = '0;
      use_clock++;
      lv = IX_L1;
      k = find_line(IX_L1, a);
      if (k < 0) begin
         o.hit_level = LVL_L2;
         o.access_cost += COST_L2;
         lv = IX_L2;
         k = find_line(IX_L2, a);
      end
      if (k < 0) begin
         o.hit_level = LVL_L3;
         o.access_cost += COST_L3;
         lv = IX_L3;
         k = find_line(IX_L3, a);
      end
      if (k < 0) begin
         o.hit_level = LVL_MAIN;
         o.access_cost += COST_MAIN;
         lv = IX_MAIN;
         k = find_line(IX_MAIN, a);
      end
      if (k < 0) begin
         o.hit_level = LVL_STORE;
         o.access_cost += COST_STORE;
         for (int j = 0; j < N_MAIN && k < 0; j++)
            if (!hierarchy[IX_MAIN][j].valid) k = j;
         if (k < 0) begin
            k = oldest_line(IX_MAIN);
            o.evict_valid = 1'b1;
            o.evict_address = hierarchy[IX_MAIN][k].addr;
         end
         hierarchy[IX_MAIN][k].valid = 1'b1;
         hierarchy[IX_MAIN][k].addr = a;
         hierarchy[IX_MAIN][k].stamp = '0;
      end
      while (lv > IX_L1) begin
         k = lift_block(lv, k);
         lv--;
      end
      hierarchy[IX_L1][k].stamp = use_clock;
      o.l1_slot = k[3:0];
      return o;
   endfunction

   // Send one word and record its expected outcome once accepted.
   task automatic send_word(bit [15:0] a);
      int n;
      req_block_address <= a;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      pending_outcomes.push_back(access_block(a));
      n = idle_length();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Response side stalls at random.
   always @(posedge clock) begin
      if (quiet) rsp_stall <= 1'b0;
      else if ($urandom_range(99) < 8) rsp_stall <= 1'b1;
      else if ($urandom_range(99) < 50) rsp_stall <= 1'b0;
   end

   // Compare each accepted response word with the oldest expectation.
   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $error("response word with no request pending");
            error_count++;
         end else begin
            e = pending_outcomes.pop_front();
            if (rsp_hit_level !== e.hit_level) begin
               $error("hit_level expected %0d got %0d", e.hit_level, rsp_hit_level);
               error_count++;
            end
            if (rsp_access_cost !== e.access_cost) begin
               $error("access_cost expected %0d got %0d", e.access_cost, rsp_access_cost);
               error_count++;
            end
            if (rsp_l1_slot !== e.l1_slot) begin
               $error("l1_slot expected %0d got %0d", e.l1_slot, rsp_l1_slot);
               error_count++;
            end
            if (rsp_evict_valid !== e.evict_valid) begin
               $error("evict_valid expected %0d got %0d", e.evict_valid, rsp_evict_valid);
               error_count++;
            end
            if (rsp_evict_address !== e.evict_address) begin
               $error("evict_address expected %h got %h", e.evict_address,
                      rsp_evict_address);
               error_count++;
            end
         end
      end
   end

   // Extremes of the address, an L1 hit, and an L1 victim coming back from L2.
   task automatic test_directed();
      send_word(16'h0000);
      send_word(16'hFFFF);
      send_word(16'h0000);
      for (int i = 1; i <= 16; i++) send_word(16'(i) ^ 16'hA500);
      send_word(16'hFFFF);
      send_word(16'h0000);
   endtask

   // Mostly a working set a bit larger than the whole hierarchy, so blocks
   // hit in every level and main memory overflows; some hot blocks and noise.
   task automatic test_random();
      int r;
      bit [15:0] a;
      for (int i = 0; i < 750; i++) begin
         quiet = (i / 100) % 3 == 1;
         r = $urandom_range(99);
         if (r < 70) a = 16'h3000 + 16'($urandom_range(419));
         else if (r < 90) a = 16'h3000 + 16'($urandom_range(24));
         else a = 16'($urandom);
         send_word(a);
      end
      quiet = 1'b0;
      req_valid <= 1'b0;
   endtask

   initial begin
      use_clock = '0;
      foreach (hierarchy[l, k]) hierarchy[l][k] = '{1'b0, 16'h0, 32'h0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   // Hard limit on the run.
   initial begin
      #8000000;
      $display("FAILURE");
      $finish;
   end

endmodule
